// ===== src/l3cf_pkg.sv =====
// package for the luma 3x3 convolution filter
// holds field widths, register codes, luma coefficients and the kernel rom
// no dependencies
package l3cf_pkg;

  localparam int COLOR_W        = 8;
  localparam int POS_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;
  localparam int SEL_W          = 4;
  localparam int DIM_W          = 12;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int MIN_DIM        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  localparam logic [SEL_W-1:0] FILTER_PASS = 4'd0;

  localparam logic [15:0] LUMA_R_COEF = 16'd77;
  localparam logic [15:0] LUMA_G_COEF = 16'd150;
  localparam logic [15:0] LUMA_B_COEF = 16'd29;

  localparam int KERNEL_COUNT = 11;
  localparam int KIDX_W       = 4;
  localparam int TAPS         = 9;
  localparam int FRAC_W       = 16;
  localparam int WEIGHT_W     = 20;
  localparam int BIAS_W       = 25;
  localparam int PROD_W       = WEIGHT_W + COLOR_W + 1;
  localparam int RSUM_W       = PROD_W + 2;
  localparam int ACC_W        = 32;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [BIAS_W-1:0]   bias_t;

  // signed 4.16 weights, taps in window order (top row first)
  localparam weight_t KERNEL_W [KERNEL_COUNT][TAPS] = '{
    '{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd65536, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
    '{20'sd25750, 20'sd50397, 20'sd12386, 20'sd22872, 20'sd44957, 20'sd11010,
      20'sd17826, 20'sd34996, 20'sd8585},
    '{20'sd0, 20'sd65536, 20'sd0, 20'sd65536, -20'sd262144, 20'sd65536,
      20'sd0, 20'sd65536, 20'sd0},
    '{20'sd0, -20'sd65536, 20'sd0, -20'sd65536, 20'sd327680, -20'sd65536,
      20'sd0, -20'sd65536, 20'sd0},
    '{20'sd4096, 20'sd8192, 20'sd4096, 20'sd8192, 20'sd16384, 20'sd8192,
      20'sd4096, 20'sd8192, 20'sd4096},
    '{-20'sd131072, -20'sd65536, 20'sd0, -20'sd65536, 20'sd65536, 20'sd65536,
      20'sd0, 20'sd65536, 20'sd131072},
    '{20'sd13933, 20'sd46871, 20'sd4732, 20'sd13933, 20'sd46871, 20'sd4732,
      20'sd13933, 20'sd46871, 20'sd4732},
    '{20'sd0, -20'sd65536, 20'sd0, -20'sd65536, 20'sd393216, -20'sd65536,
      20'sd0, -20'sd65536, 20'sd0},
    '{-20'sd65536, 20'sd0, 20'sd0, 20'sd0, -20'sd65536, 20'sd0,
      20'sd0, 20'sd0, -20'sd65536},
    '{20'sd65536, 20'sd0, 20'sd65536, 20'sd0, -20'sd131072, 20'sd0,
      20'sd65536, 20'sd0, 20'sd65536},
    '{20'sd0, 20'sd65536, 20'sd0, 20'sd0, 20'sd65536, 20'sd0,
      20'sd0, 20'sd65536, 20'sd0}
  };

  localparam bias_t KERNEL_BIAS [KERNEL_COUNT] = '{
    25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd8388608,
    25'sd0, 25'sd0, 25'sd16711680, 25'sd4194304, 25'sd2097152
  };

endpackage

// ===== src/l3cf_pixel_if.sv =====
// input pixel channel: valid/ready handshake carrying one rgb24 item
// depends on l3cf_pkg
interface l3cf_pixel_if;
  import l3cf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

// ===== src/l3cf_result_if.sv =====
// result channel: valid/ready handshake carrying one written pixel
// depends on l3cf_pkg
interface l3cf_result_if;
  import l3cf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic [POS_W-1:0]   out_column;
  logic [POS_W-1:0]   out_row;
  logic               last_of_run;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_column, output out_row, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_column, input out_row, input last_of_run,
                  output ready);
endinterface

// ===== src/l3cf_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on l3cf_pkg
interface l3cf_cfg_if;
  import l3cf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== src/luma_3x3_convolution_filter.sv =====
// luma 3x3 convolution filter: rgb24 raster stream in, filtered gray or
// passed-through pixels out; depends on l3cf_pkg and the three channel interfaces
//
// Takes one pixel per clock while the result port is ready. A pixel that yields
// two results (an interior pixel finished together with an arriving border
// pixel under an active kernel) holds the input while the first is delivered,
// since the result port delivers one item per cycle. The two line stores share
// one MAX_WIDTH x 16 memory, read at the arriving column and written back when
// that pixel next advances from the first stage; its contents are undefined
// after reset and no clearing pass is run. The 3x3 kernel uses nine parallel
// multiplies, then a registered two-level adder and clamp.
module luma_3x3_convolution_filter #(
  parameter int MAX_WIDTH  = l3cf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = l3cf_pkg::MAX_HEIGHT_DEF
) (
  input logic            clk,
  input logic            rst_n,
  l3cf_pixel_if.sink     in_px,
  l3cf_result_if.source  out_res,
  l3cf_cfg_if.sink       cfg_wr
);
  import l3cf_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int HCMP_W = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int W_RST  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int H_RST  = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] luma;
    logic [CW-1:0]      col;
    logic [RW-1:0]      row;
    logic               has_int;
    logic               has_bord;
    logic [KIDX_W-1:0]  kidx;
  } item_t;

  // configuration
  logic [SEL_W-1:0] sel_r;
  logic [CW:0]      width_r;
  logic [RW:0]      height_r;
  logic [CW:0]      width_wr;
  logic [RW:0]      height_wr;
  logic [WCMP_W-1:0] wcmp;
  logic [HCMP_W-1:0] hcmp;
  logic             cfg_fire;

  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid;

  always_comb begin
    wcmp = WCMP_W'(cfg_wr.wr_data);
    hcmp = HCMP_W'(cfg_wr.wr_data);
    if (wcmp < WCMP_W'(MIN_DIM)) begin
      width_wr = (CW + 1)'(MIN_DIM);
    end else if (wcmp > WCMP_W'(MAX_WIDTH)) begin
      width_wr = (CW + 1)'(MAX_WIDTH);
    end else begin
      width_wr = (CW + 1)'(wcmp);
    end
    if (hcmp < HCMP_W'(MIN_DIM)) begin
      height_wr = (RW + 1)'(MIN_DIM);
    end else if (hcmp > HCMP_W'(MAX_HEIGHT)) begin
      height_wr = (RW + 1)'(MAX_HEIGHT);
    end else begin
      height_wr = (RW + 1)'(hcmp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= FILTER_PASS;
      width_r  <= (CW + 1)'(W_RST);
      height_r <= (RW + 1)'(H_RST);
    end else if (cfg_fire) begin
      unique case (cfg_wr.reg_index)
        REG_FILTER_SELECT: sel_r    <= cfg_wr.wr_data[SEL_W-1:0];
        REG_FRAME_WIDTH:   width_r  <= width_wr;
        REG_FRAME_HEIGHT:  height_r <= height_wr;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic  adv;
  logic  in_fire;
  logic  v1_r, v2_r, v3_r, v4_r, vo_r;
  item_t it0, it1_r, it2_r, it3_r, it4_r, ito_r;
  logic  phase_r;
  logic  out_has;
  logic  out_first_int;
  logic  out_last;

  assign in_px.ready = adv;
  assign in_fire     = in_px.valid && adv;

  // position tracking and classification
  logic [CW-1:0] col_r, col_nxt, c0;
  logic [RW-1:0] row_r, row_nxt, r0;
  logic          wrap_col;
  logic [RW:0]   row_inc;
  logic [CW:0]   col_p1;
  logic [RW:0]   row_p1;
  logic          end_line;
  logic          border;
  logic          interior;
  logic          pass;
  logic [15:0]   luma_sum;

  always_comb begin
    wrap_col = {1'b0, col_r} >= width_r;
    c0       = wrap_col ? '0 : col_r;
    row_inc  = {1'b0, row_r} + (RW + 1)'(wrap_col);
    r0       = (row_inc >= height_r) ? '0 : row_inc[RW-1:0];
    col_p1   = {1'b0, c0} + (CW + 1)'(1);
    row_p1   = {1'b0, r0} + (RW + 1)'(1);
    end_line = col_p1 >= width_r;
    col_nxt  = end_line ? '0 : col_p1[CW-1:0];
    if (end_line) begin
      row_nxt = (row_p1 >= height_r) ? '0 : row_p1[RW-1:0];
    end else begin
      row_nxt = r0;
    end

    border   = (c0 == '0) || ({1'b0, c0} == width_r - (CW + 1)'(1)) ||
               (r0 == '0) || ({1'b0, r0} == height_r - (RW + 1)'(1));
    interior = (c0 >= CW'(2)) && (r0 >= RW'(2));
    pass     = (sel_r == FILTER_PASS) || (sel_r >= SEL_W'(KERNEL_COUNT));

    luma_sum = LUMA_R_COEF * 16'(in_px.in_red) + LUMA_G_COEF * 16'(in_px.in_green) +
               LUMA_B_COEF * 16'(in_px.in_blue);

    it0.red      = in_px.in_red;
    it0.green    = in_px.in_green;
    it0.blue     = in_px.in_blue;
    it0.luma     = luma_sum[15:8];
    it0.col      = c0;
    it0.row      = r0;
    it0.has_int  = !pass && interior;
    it0.has_bord = pass || border;
    it0.kidx     = pass ? '0 : sel_r[KIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store memory: [15:8] previous line, [7:0] line before that
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] line_rd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      line_rd_r <= line_mem[c0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      line_mem[it1_r.col] <= {it1_r.luma, line_rd_r[15:8]};
    end
  end

  // 3x3 luma window
  logic [COLOR_W-1:0] win_r [TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv && v1_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= line_rd_r[7:0];
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= line_rd_r[15:8];
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= it1_r.luma;
    end
  end

  // kernel datapath
  logic signed [PROD_W-1:0] prod     [TAPS];
  logic signed [PROD_W-1:0] prod_r   [TAPS];
  logic signed [RSUM_W-1:0] rsum     [3];
  logic signed [RSUM_W-1:0] rsum_r   [3];
  logic signed [ACC_W-1:0]  acc;
  logic [COLOR_W-1:0]       gray;
  logic [COLOR_W-1:0]       gray_r;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod[i] = PROD_W'($signed({1'b0, win_r[i]})) * PROD_W'(KERNEL_W[it2_r.kidx][i]);
    end
    for (int j = 0; j < 3; j++) begin
      rsum[j] = RSUM_W'(prod_r[3*j]) + RSUM_W'(prod_r[3*j+1]) + RSUM_W'(prod_r[3*j+2]);
    end
    acc = ACC_W'(rsum_r[0]) + ACC_W'(rsum_r[1]) + ACC_W'(rsum_r[2]) +
          ACC_W'(KERNEL_BIAS[it4_r.kidx]);
    if (acc[ACC_W-1]) begin
      gray = '0;
    end else if (|acc[ACC_W-2:FRAC_W+COLOR_W]) begin
      gray = '1;
    end else begin
      gray = acc[FRAC_W+COLOR_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r  <= it0;
      it2_r  <= it1_r;
      it3_r  <= it2_r;
      it4_r  <= it3_r;
      ito_r  <= it4_r;
      prod_r <= prod;
      rsum_r <= rsum;
      gray_r <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  // result delivery, interior result first, then the border result
  assign out_has       = vo_r && (ito_r.has_int || ito_r.has_bord);
  assign out_first_int = ito_r.has_int && !phase_r;
  assign out_last      = !out_first_int || !ito_r.has_bord;
  assign adv           = !out_has || (out_res.ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (adv) begin
      phase_r <= 1'b0;
    end else if (out_res.ready && out_has) begin
      phase_r <= 1'b1;
    end
  end

  always_comb begin
    out_res.valid       = out_has;
    out_res.last_of_run = out_last;
    if (out_first_int) begin
      out_res.out_red    = gray_r;
      out_res.out_green  = gray_r;
      out_res.out_blue   = gray_r;
      out_res.out_column = POS_W'(ito_r.col - CW'(1));
      out_res.out_row    = POS_W'(ito_r.row - RW'(1));
    end else begin
      out_res.out_red    = ito_r.red;
      out_res.out_green  = ito_r.green;
      out_res.out_blue   = ito_r.blue;
      out_res.out_column = POS_W'(ito_r.col);
      out_res.out_row    = POS_W'(ito_r.row);
    end
  end

  // checks
  a_no_mem_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && v1_r) |-> (it1_r.col != c0))
    else $error("line store read and write hit the same column");

  a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && !out_res.last_of_run) |=>
      (out_res.valid && out_res.last_of_run))
    else $error("border result missing after interior result");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ({1'b0, col_r} < $past(width_r)))
    else $error("column count left the line");

  a_phase_ok: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (vo_r && ito_r.has_int && ito_r.has_bord))
    else $error("second-result phase without a two-result item");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for luma_3x3_convolution_filter: random raster frames, kernels and geometry
// scoreboard class predicts every written pixel; needs l3cf_pkg and the channel interfaces
module tb;
  import l3cf_pkg::*;

  localparam int U            = 65536;
  localparam int LIMIT_NS     = 5_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int PIXEL_TARGET = 850;
  localparam int PHASE_CAP    = 120;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
  localparam logic [SEL_W-1:0]     FLT_BLUR      = 4'd4;
  localparam logic [SEL_W-1:0]     FLT_INVERT    = 4'd8;
  localparam logic [SEL_W-1:0]     FLT_SPARE_TOP = 4'd15;

  // nine taps in window order, then the bias, all 16.16
  localparam int FILT_TAB [KERNEL_COUNT][10] = '{
    '{0, 0, 0, 0, U, 0, 0, 0, 0, 0},
    '{25750, 50397, 12386, 22872, 44957, 11010, 17826, 34996, 8585, 0},
    '{0, U, 0, U, -4*U, U, 0, U, 0, 0},
    '{0, -U, 0, -U, 5*U, -U, 0, -U, 0, 0},
    '{4096, 8192, 4096, 8192, 16384, 8192, 4096, 8192, 4096, 0},
    '{-2*U, -U, 0, -U, U, U, 0, U, 2*U, 128*U},
    '{13933, 46871, 4732, 13933, 46871, 4732, 13933, 46871, 4732, 0},
    '{0, -U, 0, -U, 6*U, -U, 0, -U, 0, 0},
    '{-U, 0, 0, 0, -U, 0, 0, 0, -U, 255*U},
    '{U, 0, U, 0, -2*U, 0, U, 0, U, 64*U},
    '{0, U, 0, 0, U, 0, 0, U, 0, 32*U}
  };

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic               last;
  } px_item_t;

  class gray_scoreboard;
    logic [SEL_W-1:0]   sel;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COLOR_W-1:0] line_prev [MAX_WIDTH_DEF];
    logic [COLOR_W-1:0] line_prev2 [MAX_WIDTH_DEF];
    logic [COLOR_W-1:0] win [9];
    byte unsigned       writes [MAX_WIDTH_DEF];
    int                 col_cnt;
    int                 row_cnt;
    px_item_t           pending_px [$];
    int                 errors;
    int                 pixels;
    int                 results;
    int                 reg_writes;
    int                 widest;
    logic [15:0]        sel_seen;

    function new();
      sel = FILTER_PASS;
      width = DIM_W'(RESET_WIDTH);
      height = DIM_W'(RESET_HEIGHT);
      foreach (line_prev[i]) begin
        line_prev[i] = '0;
        line_prev2[i] = '0;
        writes[i] = 0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
      pixels = 0;
      results = 0;
      reg_writes = 0;
      widest = 0;
      sel_seen = '0;
    endfunction

    function int clip_dim(logic [DIM_W-1:0] v, int hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        REG_FILTER_SELECT: sel = val[SEL_W-1:0];
        REG_FRAME_WIDTH:   width = val;
        REG_FRAME_HEIGHT:  height = val;
        default: ;
      endcase
    endfunction

    // growing the line only at the first pixel of a frame or where both line stores already hold data
    function bit width_ok(int v);
      int e;
      e = clip_dim(DIM_W'(v), MAX_WIDTH_DEF);
      if (e <= clip_dim(width, MAX_WIDTH_DEF) || (col_cnt == 0 && row_cnt == 0)) return 1'b1;
      for (int c = 0; c < e; c++)
        if (writes[c] < 2) return 1'b0;
      return 1'b1;
    endfunction

    function int pixels_left();
      int w, h, c, r;
      w = clip_dim(width, MAX_WIDTH_DEF);
      h = clip_dim(height, MAX_HEIGHT_DEF);
      c = col_cnt;
      r = row_cnt;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      return (h - r) * w - c;
    endfunction

    function int pending();
      return pending_px.size();
    endfunction

    function void predict_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                 logic [COLOR_W-1:0] b);
      int w, h, c, rw, y;
      longint acc;
      logic [COLOR_W-1:0] gy;
      bit brd, thru;
      px_item_t it;
      w = clip_dim(width, MAX_WIDTH_DEF);
      h = clip_dim(height, MAX_HEIGHT_DEF);
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      c = col_cnt;
      rw = row_cnt;
      y = (77 * int'(r) + 150 * int'(g) + 29 * int'(b)) >> 8;
      win[0] = win[1];
      win[1] = win[2];
      win[3] = win[4];
      win[4] = win[5];
      win[6] = win[7];
      win[7] = win[8];
      win[2] = line_prev2[c];
      win[5] = line_prev[c];
      win[8] = y[COLOR_W-1:0];
      line_prev2[c] = line_prev[c];
      line_prev[c] = y[COLOR_W-1:0];
      if (writes[c] < 2) writes[c]++;
      brd = (c == 0) || (c == w - 1) || (rw == 0) || (rw == h - 1);
      thru = (sel == FILTER_PASS) || (sel >= KERNEL_COUNT);
      sel_seen[sel] = 1'b1;
      if (!thru && c >= 2 && rw >= 2) begin
        acc = FILT_TAB[sel][9];
        for (int i = 0; i < 9; i++) acc += longint'(win[i]) * FILT_TAB[sel][i];
        if (acc < 0) gy = '0;
        else if ((acc >>> FRAC_W) > 255) gy = 8'hFF;
        else gy = COLOR_W'(acc >>> FRAC_W);
        it = '{gy, gy, gy, POS_W'(c - 1), POS_W'(rw - 1), !brd};
        pending_px.push_back(it);
      end
      if (thru || brd) begin
        it = '{r, g, b, POS_W'(c), POS_W'(rw), 1'b1};
        pending_px.push_back(it);
      end
      pixels++;
      if (w > widest) widest = w;
      col_cnt = c + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = rw + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void cmp_field(string nm, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(px_item_t got);
      px_item_t want;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rgb %h %h %h col %0d row %0d",
                 $time, got.red, got.green, got.blue, got.column, got.row);
        errors++;
        return;
      end
      want = pending_px.pop_front();
      results++;
      cmp_field("red", want.red, got.red);
      cmp_field("green", want.green, got.green);
      cmp_field("blue", want.blue, got.blue);
      cmp_field("column", want.column, got.column);
      cmp_field("row", want.row, got.row);
      cmp_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  bit   hold_req;

  gray_scoreboard sb = new();

  l3cf_pixel_if  px_if();
  l3cf_result_if res_if();
  l3cf_cfg_if    cfg_if();

  luma_3x3_convolution_filter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (px_if),
    .out_res(res_if),
    .cfg_wr (cfg_if)
  );

  always #6 clk = ~clk;

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 32);
  endfunction

  function automatic logic [23:0] rand_pixel();
    logic [COLOR_W-1:0] v;
    logic [23:0] p;
    case ($urandom_range(0, 3))
      0: begin
        p[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        v = COLOR_W'($urandom_range(0, 255));
        p = {v, v, v};
      end
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_pixel(input logic [23:0] p);
    while (take_gap()) begin
      px_if.valid <= 1'b0;
      @(posedge clk);
    end
    px_if.valid <= 1'b1;
    {px_if.in_red, px_if.in_green, px_if.in_blue} <= p;
    @(posedge clk);
    while (!px_if.ready) @(posedge clk);
    sb.predict_pixel(p[23:16], p[15:8], p[7:0]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idx);
    int w_new, h_new, left, cnt, k, kind;
    logic [SEL_W-1:0] s;
    settle();
    steady = (idx >= 10 && idx < 18);
    k = $urandom_range(0, 9);
    if (k == 0) s = FILTER_PASS;
    else if (k == 1) s = SEL_W'($urandom_range(KERNEL_COUNT, 15));
    else s = SEL_W'($urandom_range(1, KERNEL_COUNT - 1));
    write_reg(REG_FILTER_SELECT, {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, s});
    if ($urandom_range(0, 4) < 3) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        w_new = $urandom_range(0, 1) ? MAX_WIDTH_DEF : $urandom_range(MAX_WIDTH_DEF + 1, 4095);
        h_new = $urandom_range(3, 4);
      end else if (kind == 1) begin
        w_new = $urandom_range(3, 5);
        h_new = $urandom_range(0, 1) ? MAX_HEIGHT_DEF : $urandom_range(MAX_HEIGHT_DEF + 1, 4095);
      end else if (kind == 2) begin
        w_new = $urandom_range(0, 3);
        h_new = $urandom_range(0, 4);
      end else begin
        w_new = $urandom_range(3, 12);
        h_new = $urandom_range(3, 8);
      end
      if (sb.width_ok(w_new)) write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_new));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_new));
    end
    left = sb.pixels_left();
    if (left > 300) cnt = $urandom_range(8, 48);
    else begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, left) : left;
      if ($urandom_range(0, 2) == 0) cnt += $urandom_range(1, 60);
    end
    if (cnt > PHASE_CAP) cnt = PHASE_CAP;
    if (cnt > PIXEL_TARGET - sb.pixels) cnt = PIXEL_TARGET - sb.pixels;
    if (cnt < 1) cnt = 1;
    if (idx == 5 || idx == 14) begin
      hold_req = 1'b1;
      cnt = 120;
    end
    for (k = 0; k < cnt; k++) send_pixel(rand_pixel());
    px_if.valid <= 1'b0;
  endtask

  // result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    px_item_t got;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got.red = res_if.out_red;
        got.green = res_if.out_green;
        got.blue = res_if.out_blue;
        got.column = res_if.out_column;
        got.row = res_if.out_row;
        got.last = res_if.last_of_run;
        sb.check_pixel(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !take_gap();
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int k, phase;
    steady = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    px_if.valid <= 1'b0;
    px_if.in_red <= '0;
    px_if.in_green <= '0;
    px_if.in_blue <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.reg_index <= REG_FILTER_SELECT;
    cfg_if.wr_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry, passthrough
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    px_if.valid <= 1'b0;

    // undersized geometry clamps to 3x3, line wraps mid-frame, checkerboard under blur
    settle();
    write_reg(REG_FILTER_SELECT, {8'h00, FLT_BLUR});
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    for (k = 0; k < 6; k++) send_pixel((k % 2) ? 24'h000000 : 24'hFFFFFF);
    px_if.valid <= 1'b0;

    // unused kernel index and oversized geometry
    settle();
    write_reg(REG_FILTER_SELECT, {8'hFF, FLT_SPARE_TOP});
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    send_pixel(24'h808080);
    send_pixel(24'h7F7F7F);
    send_pixel(rand_pixel());
    px_if.valid <= 1'b0;

    // spare register, line shrinks mid-row, pixels with no result
    settle();
    write_reg(REG_SPARE, 12'hA5C);
    write_reg(REG_FILTER_SELECT, {8'h00, FLT_INVERT});
    write_reg(REG_FRAME_WIDTH, 12'd3);
    for (k = 0; k < 6; k++) send_pixel(rand_pixel());
    px_if.valid <= 1'b0;

    phase = 0;
    while (sb.pixels < PIXEL_TARGET) begin
      run_phase(phase);
      phase++;
    end
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d pixels, %0d results, %0d register writes over %0d phases",
             sb.pixels, sb.results, sb.reg_writes, phase);
    $display("widest line %0d, kernel selects seen %b", sb.widest, sb.sel_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/l3cf_pkg.sv
src/l3cf_pixel_if.sv
src/l3cf_result_if.sv
src/l3cf_cfg_if.sv
src/luma_3x3_convolution_filter.sv
tb/tb.sv
